@@ rtl/keyframe_position_interpolator_core_assert.svh @@
// Assertion macros for the keyframe position interpolator; sampled on clk, off in reset.
`ifndef KEYFRAME_POSITION_INTERPOLATOR_CORE_ASSERT_SVH
`define KEYFRAME_POSITION_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define KPI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KPI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/kpi_pkg.sv @@
// Types and constants shared by the keyframe position interpolator modules.
`default_nettype none
package kpi_pkg;
	localparam int COORD_W = 24;
	localparam int TIME_W  = 32;
	localparam int SEG_W   = 7;
	localparam int SLOT_W  = 6;
	localparam int PROG_W  = 16;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic                      action;
		logic [SLOT_W-1:0]         wp_index;
		logic signed [COORD_W-1:0] wp_x;
		logic signed [COORD_W-1:0] wp_y;
		logic [TIME_W-1:0]         wp_time;
		logic [TIME_W-1:0]         query_time;
	} cmd_t;

	typedef struct packed {
		logic [SEG_W-1:0]          segment_index;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
	} result_t;

	// One stored waypoint.
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [TIME_W-1:0]         wtime;
	} entry_t;
endpackage
`default_nettype wire

@@ rtl/kpi_store.sv @@
// Waypoint table: one write port and one registered read port.
`default_nettype none
module kpi_store import kpi_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire entry_t        wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output entry_t             rd_data
);
	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;
endmodule
`default_nettype wire

@@ rtl/kpi_div.sv @@
// Restoring divider giving a 16-bit fraction num/den with num < den, one bit per cycle.
`default_nettype none
module kpi_div import kpi_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [TIME_W-1:0] num,
	input  wire logic [TIME_W-1:0] den,
	output logic                   done,
	output logic [PROG_W-1:0]      quo
);
	localparam int CNT_W = $clog2(PROG_W + 1);

	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] den_q;
	logic [PROG_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [TIME_W:0]   shifted;
	logic              fits;

	assign shifted = {rem_q, 1'b0};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(PROG_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			// The remainder stays below den, so the difference fits the register.
			rem_q <= fits ? TIME_W'(shifted - {1'b0, den_q}) : shifted[TIME_W-1:0];
			quo_q <= {quo_q[PROG_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

@@ rtl/kpi_lerp.sv @@
// Shared interpolation unit: a + ((b - a) * prog) >>> 16, product registered.
`default_nettype none
module kpi_lerp import kpi_pkg::*; (
	input  wire logic                      clk,
	input  wire logic signed [COORD_W-1:0] a,
	input  wire logic signed [COORD_W-1:0] b,
	input  wire logic [PROG_W-1:0]         prog,
	output logic signed [COORD_W-1:0]      y
);
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = DIFF_W + PROG_W + 1;

	logic signed [DIFF_W-1:0]  diff;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [COORD_W-1:0] a_s1;
	logic signed [PROD_W-1:0]  sum;

	assign diff = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});

	always_ff @(posedge clk) begin
		prod_s1 <= diff * $signed({1'b0, prog});
		a_s1    <= a;
	end

	// The result lies between a and b, so the low bits are the whole answer.
	assign sum = PROD_W'(a_s1) + (prod_s1 >>> PROG_W);
	assign y   = sum[COORD_W-1:0];
endmodule
`default_nettype wire

@@ rtl/keyframe_position_interpolator_core.sv @@
// Top level of the keyframe position interpolator: sequencer, count register, result register.
//
// Usage. An item is taken at a clock edge with start high and busy low. A write
// item (action 0) stores x, y and time in slot wp_index at that edge and
// leaves busy low. A query item (action 1) raises busy while the table is scanned.
// The scan reads one waypoint at a time, in a fetch state and then a check state,
// through the single table read port. A query that lands before the first
// waypoint ends on its first check, one past the last after the whole scan; one
// that falls inside a segment goes on after the waypoint that closes it: the
// divider state (16 quotient bits and a step to see them done), two passes through
// the shared multiplier, then the wrap state. The result beat shows on result
// for exactly one cycle with done high, in the cycle busy drops; the receiver
// cannot stall it. waypoint_count is written on the cfg channel, which is always
// ready; write it only while busy is low. Reset clears the sequencer and sets the
// count to one; the table is not cleared and must be written before it is queried.
`default_nettype none
`include "keyframe_position_interpolator_core_assert.svh"
module keyframe_position_interpolator_core import kpi_pkg::*; #(
	parameter int MAX_WAYPOINTS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire cmd_t             cmd,
	output logic                  done,
	output result_t               result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [SEG_W-1:0] cfg_data
);
	localparam int AW = $clog2(MAX_WAYPOINTS);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_FETCH = 7'b0000010,
		ST_CHECK = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_MULX  = 7'b0010000,
		ST_MULY  = 7'b0100000,
		ST_WRAP  = 7'b1000000
	} state_t;

	state_t                    state_q;
	logic [SEG_W-1:0]          count_q;
	logic [SEG_W-1:0]          cnt_q;
	logic [SEG_W-1:0]          idx_q;
	logic [SEG_W-1:0]          seg_q;
	logic [TIME_W-1:0]         t_q;
	entry_t                    prev_q;
	entry_t                    next_q;
	logic signed [COORD_W-1:0] pos_x_q;
	logic                      done_q;
	result_t                   result_q;

	logic [SEG_W-1:0]          cnt_clamp;
	logic                      accept;
	logic                      wr_en;
	entry_t                    wr_data;
	entry_t                    rd;
	logic                      div_start;
	logic                      div_done;
	logic [PROG_W-1:0]         div_quo;
	logic signed [COORD_W-1:0] lerp_a;
	logic signed [COORD_W-1:0] lerp_b;
	logic signed [COORD_W-1:0] lerp_y;

	assign accept    = start && !busy;
	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (count_q == '0) begin
			cnt_clamp = SEG_W'(1);
		end else if (32'(count_q) > 32'(MAX_WAYPOINTS)) begin
			cnt_clamp = SEG_W'(MAX_WAYPOINTS);
		end else begin
			cnt_clamp = count_q;
		end
	end

	// Slots past the table depth are dropped.
	assign wr_en = accept && (cmd.action == ACT_WRITE)
		&& (32'(cmd.wp_index) < 32'(MAX_WAYPOINTS));
	assign wr_data = '{x: cmd.wp_x, y: cmd.wp_y, wtime: cmd.wp_time};

	kpi_store #(.DEPTH(MAX_WAYPOINTS)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(cmd.wp_index)),
		.wr_data (wr_data),
		.rd_addr (AW'(idx_q)),
		.rd_data (rd)
	);

	assign div_start = (state_q == ST_CHECK) && (idx_q != '0) && (t_q < rd.wtime);

	kpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (t_q - prev_q.wtime),
		.den    (rd.wtime - prev_q.wtime),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign lerp_a = (state_q == ST_MULX) ? prev_q.x : prev_q.y;
	assign lerp_b = (state_q == ST_MULX) ? next_q.x : next_q.y;

	kpi_lerp u_lerp (
		.clk  (clk),
		.a    (lerp_a),
		.b    (lerp_b),
		.prog (div_quo),
		.y    (lerp_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= SEG_W'(1);
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd.action == ACT_QUERY) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (idx_q == '0 && t_q < rd.wtime) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (t_q >= rd.wtime) begin
						if ((idx_q + SEG_W'(1)) == cnt_q) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_FETCH;
						end
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MULX;
					end
				end
				ST_MULX: begin
					state_q <= ST_MULY;
				end
				ST_MULY: begin
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					t_q   <= cmd.query_time;
					cnt_q <= cnt_clamp;
					idx_q <= '0;
				end
			end
			ST_CHECK: begin
				if (idx_q == '0 && t_q < rd.wtime) begin
					result_q <= '{segment_index: '0, pos_x: rd.x, pos_y: rd.y};
				end else if (t_q >= rd.wtime) begin
					prev_q   <= rd;
					idx_q    <= idx_q + SEG_W'(1);
					result_q <= '{segment_index: cnt_q, pos_x: rd.x, pos_y: rd.y};
				end else begin
					next_q <= rd;
					seg_q  <= idx_q;
				end
			end
			ST_MULY: begin
				pos_x_q <= lerp_y;
			end
			ST_WRAP: begin
				result_q <= '{segment_index: seg_q, pos_x: pos_x_q, pos_y: lerp_y};
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	`KPI_ASSERT_NOW(a_seg_in_range, done, result.segment_index <= cnt_q, "segment index past count")
	`KPI_ASSERT_NOW(a_done_ends_work, done, !busy, "result beat while still busy")
	`KPI_ASSERT_NEXT(a_query_busy, accept && cmd.action == ACT_QUERY, busy, "query did not start")
	`KPI_ASSERT_NEXT(a_single_beat, done, !done, "result beat repeated")
endmodule
`default_nettype wire
